/* hdl/nsqrt_pkg.sv */
// Constants and widths shared by the Newton-Raphson square root block.
// No dependencies.
`default_nettype none

package nsqrt_pkg;

  localparam int unsigned DataWidth = 32;  // radicand width, Q16.16
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DividendW = DataWidth + FracBits;  // radicand scaled by 2^FracBits
  localparam int unsigned RootW     = 24;
  localparam int unsigned StepW     = 6;
  localparam int unsigned TolW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivCntW   = $clog2(DividendW);

  localparam logic [RootW-1:0] RootMax = {RootW{1'b1}};

  localparam logic [TolW-1:0]  TolReset      = TolW'(1);
  localparam logic [StepW-1:0] MaxStepsReset = StepW'(32);

  localparam logic [CfgIdxW-1:0] RegTolerance = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxSteps  = CfgIdxW'(1);

endpackage

`default_nettype wire

/* hdl/newton_square_root.sv */
// Newton-Raphson square root of an unsigned Q16.16 radicand, root in Q8.16 (saturated).
// Each step is a restoring divide of the scaled radicand by the estimate, then an update;
// a zero radicand skips the divide. One request at a time: no new radicand is taken
// until the result is registered; the 48-bit shift-subtract divider sets the pace.
// Reset: asynchronous, active low; tolerance returns to 1, max_steps to 32, no result.
// Depends on nsqrt_pkg.
`default_nettype none

module newton_square_root (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [nsqrt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [nsqrt_pkg::TolW-1:0]    cfg_data_i,
  // Radicand requests
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] radicand
  // Results
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [23:0] root, [29:24] steps_taken, [31:30] zero
  output      logic        m_axis_tuser    // [0] converged
);

  localparam int unsigned DW = nsqrt_pkg::DataWidth;
  localparam int unsigned NW = nsqrt_pkg::DividendW;
  localparam int unsigned SW = nsqrt_pkg::StepW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [nsqrt_pkg::TolW-1:0] tol_q;
  logic [SW-1:0]              max_steps_q;

  // Iteration state
  logic [NW-1:0] dividend_q;  // radicand << FracBits, kept for every step
  logic [NW-1:0] quo_q;       // divider shift register: dividend bits out, quotient bits in
  logic [DW-1:0] rem_q;       // partial remainder, always below the divisor
  logic [DW-1:0] x_q;         // current estimate, also the divisor
  logic [nsqrt_pkg::DivCntW-1:0] bit_cnt_q;
  logic [SW-1:0] steps_q;
  logic          conv_q;

  // Output register
  logic                       out_valid_q;
  logic [nsqrt_pkg::RootW-1:0] out_root_q;
  logic [SW-1:0]              out_steps_q;
  logic                       out_conv_q;

  // Shared divider datapath: one restoring step per cycle
  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_trial;
  logic          q_bit;

  assign rem_shift = {rem_q, quo_q[NW-1]};
  assign rem_trial = rem_shift - {1'b0, x_q};
  assign q_bit     = (rem_shift >= {1'b0, x_q});

  // Newton update: nx = floor((x + q) / 2)
  logic [NW:0]   upd_sum;
  logic [NW-1:0] nx;
  logic [NW-1:0] x_ext;
  logic [NW-1:0] diff;
  logic          step_conv;
  logic [SW-1:0] steps_inc;
  logic [SW-1:0] limit;
  logic [DW-1:0] x_new;

  assign upd_sum   = {1'b0, x_ext} + {1'b0, quo_q};
  assign nx        = upd_sum[NW:1];
  assign x_ext     = {{(NW-DW){1'b0}}, x_q};
  assign diff      = (nx > x_ext) ? (nx - x_ext) : (x_ext - nx);
  assign step_conv = (diff <= {{(NW-nsqrt_pkg::TolW){1'b0}}, tol_q});
  assign steps_inc = steps_q + SW'(1);
  // A limit of zero still takes one step
  assign limit     = (max_steps_q == '0) ? SW'(1) : max_steps_q;
  // The estimate never leaves 32 bits for a nonzero radicand; keep the divisor nonzero
  assign x_new     = (nx == '0) ? DW'(1) : nx[DW-1:0];

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_steps_q, out_root_q};
  assign m_axis_tuser  = out_conv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tol_q       <= nsqrt_pkg::TolReset;
      max_steps_q <= nsqrt_pkg::MaxStepsReset;
      dividend_q  <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      x_q         <= '0;
      bit_cnt_q   <= '0;
      steps_q     <= '0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_root_q  <= '0;
      out_steps_q <= '0;
      out_conv_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          nsqrt_pkg::RegTolerance: tol_q       <= cfg_data_i;
          nsqrt_pkg::RegMaxSteps:  max_steps_q <= cfg_data_i[SW-1:0];
          default: ;  // unmapped index: drop the write
        endcase
      end

      // Drain the result register unless a new result replaces it this cycle
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x_q        <= s_axis_tdata[DW-1:0];
            dividend_q <= {s_axis_tdata[DW-1:0], {nsqrt_pkg::FracBits{1'b0}}};
            quo_q      <= {s_axis_tdata[DW-1:0], {nsqrt_pkg::FracBits{1'b0}}};
            rem_q      <= '0;
            bit_cnt_q  <= nsqrt_pkg::DivCntW'(NW - 1);
            steps_q    <= '0;
            if (s_axis_tdata[DW-1:0] == '0) begin
              // Zero radicand: root zero, converged, no division
              conv_q  <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              conv_q  <= 1'b0;
              state_q <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          quo_q     <= {quo_q[NW-2:0], q_bit};
          rem_q     <= q_bit ? rem_trial[DW-1:0] : rem_shift[DW-1:0];
          bit_cnt_q <= bit_cnt_q - nsqrt_pkg::DivCntW'(1);
          if (bit_cnt_q == '0) begin
            state_q <= ST_UPD;
          end
        end

        ST_UPD: begin
          x_q     <= x_new;
          steps_q <= steps_inc;
          if (step_conv || (steps_inc >= limit)) begin
            conv_q  <= step_conv;
            state_q <= ST_DONE;
          end else begin
            // Start the next divide
            quo_q     <= dividend_q;
            rem_q     <= '0;
            bit_cnt_q <= nsqrt_pkg::DivCntW'(NW - 1);
            state_q   <= ST_DIV;
          end
        end

        ST_DONE: begin
          // Hold until the result register can take the result
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_root_q  <= (x_q > DW'(nsqrt_pkg::RootMax)) ? nsqrt_pkg::RootMax
                                                          : x_q[nsqrt_pkg::RootW-1:0];
            out_steps_q <= steps_q;
            out_conv_q  <= conv_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
